>>> rtl/mgrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mgrp_pkg;

  // Prime modulus and derived constants
  localparam int unsigned VAL_W = 30;
  localparam logic [29:0] MODULUS     = 30'd1000000007;
  localparam logic [29:0] MODULUS_M2  = 30'd1000000005;
  localparam logic [31:0] MODULUS_X1  = 32'd1000000007;
  localparam logic [31:0] MODULUS_X2  = 32'd2000000014;

  // Barrett constant floor(2^60 / P), fits in 31 bits
  localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);

  // Multiplier operation codes: operand pair and destination register
  typedef logic [2:0] mgrp_op_t;
  localparam mgrp_op_t OP_SQB  = 3'd0;  // base square
  localparam mgrp_op_t OP_HI   = 3'd1;  // upper power accumulate
  localparam mgrp_op_t OP_LO   = 3'd2;  // lower power accumulate
  localparam mgrp_op_t OP_SQC  = 3'd3;  // (base-1) square
  localparam mgrp_op_t OP_INV  = 3'd4;  // inverse accumulate
  localparam mgrp_op_t OP_TERM = 3'd5;  // range sum = diff * inverse
  localparam mgrp_op_t OP_PROD = 3'd6;  // running product update

  // Reduction step select: subtract P shifted left by this amount
  localparam logic [1:0] RED_FIRST = 2'd2;

  // Tag that travels with a multiplier operation
  typedef struct packed {
    mgrp_op_t op;
    logic     wr;
  } mgrp_tag_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       red_step;
    logic [1:0] red_sel;
    logic       issue;
    mgrp_op_t   op;
    logic       shift;
    logic       emit;
  } mgrp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic one;
    logic last;
    logic busy;
  } mgrp_sts_t;

endpackage

`default_nettype wire

>>> rtl/modular_geometric_range_product_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Computes, per item, the sum of base^k for k in [low_exponent, high_exponent]
// modulo 1000000007 and multiplies it into a running product; an item with
// last_term set delivers the product on the out_ channel and restarts it at 1.
// One item is worked at a time. A general base runs R rounds, with
// R = max(min(EXP_BITS,32) + 1, 30), and the next item can transfer once
// the block is idle again: each round handles one exponent bit for three
// interleaved square-and-multiply exponentiations (upper power, lower
// power, Fermat inverse) as five operations on one four-stage Barrett
// multiplier; the multiplier is drained after the rounds, after the range
// sum and after the product update. Base one skips the exponentiations.
// A finished product waits in the output register while the next item is
// taken in; a product that finds that register still stalled holds the
// block until the out_ side takes the waiting one.
module modular_geometric_range_product_core #(
  parameter int unsigned EXP_BITS = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [29:0] in_base,
  input  wire  [31:0] in_low_exponent,
  input  wire  [31:0] in_high_exponent,
  input  wire         in_last_term,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [29:0] out_product
);

  mgrp_pkg::mgrp_cmd_t cmd;
  mgrp_pkg::mgrp_sts_t sts;

  mgrp_ctrl #(
    .EXP_BITS (EXP_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  mgrp_datapath #(
    .EXP_BITS (EXP_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_base          (in_base),
    .in_low_exponent  (in_low_exponent),
    .in_high_exponent (in_high_exponent),
    .in_last_term     (in_last_term),
    .out_product      (out_product)
  );

  // A new item only enters with the multiplier drained
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !sts.busy)
    else $error("item transfer with multiplier busy");

  // The output register is loaded only when it is free
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

  // Delivered products are fully reduced
  a_out_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_product < mgrp_pkg::MODULUS))
    else $error("product not reduced modulo P");

  // Multiplier operations are issued only while an item is in work
  a_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> in_stall)
    else $error("multiply issued while idle");

endmodule

`default_nettype wire

>>> rtl/mgrp_modmul.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined modular multiplier, Barrett reduction, four register stages.
module mgrp_modmul (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  input  mgrp_pkg::mgrp_tag_t   in_tag,
  input  wire  [29:0]           in_a,
  input  wire  [29:0]           in_b,
  output logic                  out_valid,
  output mgrp_pkg::mgrp_tag_t   out_tag,
  output logic [29:0]           out_res,
  output logic                  busy
);

  logic                v1_r, v2_r, v3_r, v4_r;
  logic                v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  mgrp_pkg::mgrp_tag_t tag1_r, tag2_r, tag3_r, tag4_r;
  mgrp_pkg::mgrp_tag_t tag1_nxt, tag2_nxt, tag3_nxt, tag4_nxt;
  logic [59:0]         x_r, x_nxt;
  logic [61:0]         t_r, t_nxt;
  logic [31:0]         xlo2_r, xlo2_nxt;
  logic [31:0]         xlo3_r, xlo3_nxt;
  logic [31:0]         qp_r, qp_nxt;
  logic [31:0]         rem_r, rem_nxt;

  // Stage logic: product, quotient estimate, q*P, remainder
  always_comb begin
    v1_nxt   = in_valid;
    tag1_nxt = in_tag;
    x_nxt    = 60'(in_a) * 60'(in_b);

    v2_nxt   = v1_r;
    tag2_nxt = tag1_r;
    xlo2_nxt = x_r[31:0];
    t_nxt    = 62'(x_r[59:29]) * 62'(mgrp_pkg::BARRETT_MU);

    v3_nxt   = v2_r;
    tag3_nxt = tag2_r;
    xlo3_nxt = xlo2_r;
    qp_nxt   = 32'(61'(t_r[61:31]) * 61'(mgrp_pkg::MODULUS));

    // true remainder is below 3P, so 32-bit wraparound is exact
    v4_nxt   = v3_r;
    tag4_nxt = tag3_r;
    rem_nxt  = xlo3_r - qp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag1_r <= tag1_nxt;
    tag2_r <= tag2_nxt;
    tag3_r <= tag3_nxt;
    tag4_r <= tag4_nxt;
    x_r    <= x_nxt;
    t_r    <= t_nxt;
    xlo2_r <= xlo2_nxt;
    xlo3_r <= xlo3_nxt;
    qp_r   <= qp_nxt;
    rem_r  <= rem_nxt;
  end

  // Final correction: at most two subtractions of P
  always_comb begin
    if (rem_r >= mgrp_pkg::MODULUS_X2) begin
      out_res = 30'(rem_r - mgrp_pkg::MODULUS_X2);
    end else if (rem_r >= mgrp_pkg::MODULUS_X1) begin
      out_res = 30'(rem_r - mgrp_pkg::MODULUS_X1);
    end else begin
      out_res = rem_r[29:0];
    end
  end

  assign out_valid = v4_r;
  assign out_tag   = tag4_r;
  assign busy      = v1_r | v2_r | v3_r | v4_r;

endmodule

`default_nettype wire

>>> rtl/mgrp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mgrp_datapath #(
  parameter int unsigned EXP_BITS = 32
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  mgrp_pkg::mgrp_cmd_t  cmd,
  output mgrp_pkg::mgrp_sts_t  sts,
  input  wire  [29:0]          in_base,
  input  wire  [31:0]          in_low_exponent,
  input  wire  [31:0]          in_high_exponent,
  input  wire                  in_last_term,
  output logic [29:0]          out_product
);

  localparam int unsigned EW = (EXP_BITS < 32) ? EXP_BITS : 32;
  localparam int unsigned XW = EW + 1;

  logic [XW-1:0] exp_hi_r, exp_hi_nxt;
  logic [XW-1:0] exp_lo_r, exp_lo_nxt;
  logic [29:0]   pm2_r, pm2_nxt;
  logic [29:0]   sq_b_r, sq_b_nxt;
  logic [29:0]   sq_c_r, sq_c_nxt;
  logic [29:0]   acc_hi_r, acc_hi_nxt;
  logic [29:0]   acc_lo_r, acc_lo_nxt;
  logic [29:0]   acc_inv_r, acc_inv_nxt;
  logic [29:0]   term_r, term_nxt;
  logic [29:0]   prod_r, prod_nxt;
  logic [29:0]   out_product_r, out_product_nxt;
  logic          one_r, one_nxt;
  logic          last_r, last_nxt;

  logic [29:0]   base_red, base_dec;
  logic [33:0]   hi_ext, lo_ext, red_m, hi_red, lo_red;
  logic [29:0]   diff_a, diff_b, diff;
  logic [29:0]   mm_a, mm_b;
  mgrp_pkg::mgrp_tag_t mm_tag, mm_out_tag;
  logic          mm_out_valid, mm_busy;
  logic [29:0]   mm_res;

  // Base reduced below P, and base - 1 modulo P
  always_comb begin
    base_red = (in_base >= mgrp_pkg::MODULUS) ? in_base - mgrp_pkg::MODULUS : in_base;
    base_dec = (base_red == 30'd0) ? mgrp_pkg::MODULUS - 30'd1 : base_red - 30'd1;
  end

  // One conditional subtract of P << red_sel on both counts (base one)
  always_comb begin
    hi_ext = 34'(exp_hi_r);
    lo_ext = 34'(exp_lo_r);
    case (cmd.red_sel)
      2'd2:    red_m = 34'(mgrp_pkg::MODULUS) << 2;
      2'd1:    red_m = 34'(mgrp_pkg::MODULUS) << 1;
      default: red_m = 34'(mgrp_pkg::MODULUS);
    endcase
    hi_red = (hi_ext >= red_m) ? hi_ext - red_m : hi_ext;
    lo_red = (lo_ext >= red_m) ? lo_ext - red_m : lo_ext;
  end

  // Upper minus lower modulo P
  always_comb begin
    diff_a = one_r ? hi_ext[29:0] : acc_hi_r;
    diff_b = one_r ? lo_ext[29:0] : acc_lo_r;
    diff   = 30'(31'(diff_a) + 31'(mgrp_pkg::MODULUS) - 31'(diff_b));
    if (diff_a >= diff_b) begin
      diff = diff_a - diff_b;
    end
  end

  // Operand select for the multiplier
  always_comb begin
    mm_a       = '0;
    mm_b       = '0;
    mm_tag.op  = cmd.op;
    mm_tag.wr  = 1'b0;
    case (cmd.op)
      mgrp_pkg::OP_SQB: begin
        mm_a = sq_b_r;    mm_b = sq_b_r;  mm_tag.wr = 1'b1;
      end
      mgrp_pkg::OP_HI: begin
        mm_a = acc_hi_r;  mm_b = sq_b_r;  mm_tag.wr = exp_hi_r[0];
      end
      mgrp_pkg::OP_LO: begin
        mm_a = acc_lo_r;  mm_b = sq_b_r;  mm_tag.wr = exp_lo_r[0];
      end
      mgrp_pkg::OP_SQC: begin
        mm_a = sq_c_r;    mm_b = sq_c_r;  mm_tag.wr = 1'b1;
      end
      mgrp_pkg::OP_INV: begin
        mm_a = acc_inv_r; mm_b = sq_c_r;  mm_tag.wr = pm2_r[0];
      end
      mgrp_pkg::OP_TERM: begin
        mm_a = diff;      mm_b = acc_inv_r; mm_tag.wr = 1'b1;
      end
      mgrp_pkg::OP_PROD: begin
        mm_a = prod_r;    mm_b = term_r;  mm_tag.wr = 1'b1;
      end
      default: begin
        mm_tag.wr = 1'b0;
      end
    endcase
  end

  mgrp_modmul u_modmul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd.issue),
    .in_tag    (mm_tag),
    .in_a      (mm_a),
    .in_b      (mm_b),
    .out_valid (mm_out_valid),
    .out_tag   (mm_out_tag),
    .out_res   (mm_res),
    .busy      (mm_busy)
  );

  // Register updates: load, reduction, exponent shift, write-back, emit
  always_comb begin
    exp_hi_nxt      = exp_hi_r;
    exp_lo_nxt      = exp_lo_r;
    pm2_nxt         = pm2_r;
    sq_b_nxt        = sq_b_r;
    sq_c_nxt        = sq_c_r;
    acc_hi_nxt      = acc_hi_r;
    acc_lo_nxt      = acc_lo_r;
    acc_inv_nxt     = acc_inv_r;
    term_nxt        = term_r;
    prod_nxt        = prod_r;
    out_product_nxt = out_product_r;
    one_nxt         = one_r;
    last_nxt        = last_r;

    // load, red_step and shift come from different controller states
    if (cmd.load) begin
      exp_hi_nxt  = XW'(in_high_exponent[EW-1:0]) + XW'(1);
      exp_lo_nxt  = XW'(in_low_exponent[EW-1:0]);
      pm2_nxt     = mgrp_pkg::MODULUS_M2;
      sq_b_nxt    = base_red;
      sq_c_nxt    = base_dec;
      acc_hi_nxt  = 30'd1;
      acc_lo_nxt  = 30'd1;
      acc_inv_nxt = 30'd1;
      one_nxt     = (base_red == 30'd1);
      last_nxt    = in_last_term;
    end else if (cmd.red_step) begin
      exp_hi_nxt = XW'(hi_red);
      exp_lo_nxt = XW'(lo_red);
    end else if (cmd.shift) begin
      exp_hi_nxt = exp_hi_r >> 1;
      exp_lo_nxt = exp_lo_r >> 1;
      pm2_nxt    = pm2_r >> 1;
    end

    if (mm_out_valid && mm_out_tag.wr) begin
      case (mm_out_tag.op)
        mgrp_pkg::OP_SQB:  sq_b_nxt    = mm_res;
        mgrp_pkg::OP_HI:   acc_hi_nxt  = mm_res;
        mgrp_pkg::OP_LO:   acc_lo_nxt  = mm_res;
        mgrp_pkg::OP_SQC:  sq_c_nxt    = mm_res;
        mgrp_pkg::OP_INV:  acc_inv_nxt = mm_res;
        mgrp_pkg::OP_TERM: term_nxt    = mm_res;
        mgrp_pkg::OP_PROD: prod_nxt    = mm_res;
        default:           term_nxt    = term_r;
      endcase
    end

    if (cmd.emit) begin
      out_product_nxt = prod_r;
      prod_nxt        = 30'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r <= 30'd1;
    end else begin
      prod_r <= prod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    exp_hi_r      <= exp_hi_nxt;
    exp_lo_r      <= exp_lo_nxt;
    pm2_r         <= pm2_nxt;
    sq_b_r        <= sq_b_nxt;
    sq_c_r        <= sq_c_nxt;
    acc_hi_r      <= acc_hi_nxt;
    acc_lo_r      <= acc_lo_nxt;
    acc_inv_r     <= acc_inv_nxt;
    term_r        <= term_nxt;
    out_product_r <= out_product_nxt;
    one_r         <= one_nxt;
    last_r        <= last_nxt;
  end

  assign sts.one     = one_r;
  assign sts.last    = last_r;
  assign sts.busy    = mm_busy;
  assign out_product = out_product_r;

endmodule

`default_nettype wire

>>> rtl/mgrp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mgrp_ctrl #(
  parameter int unsigned EXP_BITS = 32
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire                  out_stall,
  output mgrp_pkg::mgrp_cmd_t  cmd,
  input  mgrp_pkg::mgrp_sts_t  sts
);

  localparam int unsigned EW     = (EXP_BITS < 32) ? EXP_BITS : 32;
  localparam int unsigned ROUNDS = (EW + 1 > 30) ? EW + 1 : 30;
  localparam int unsigned RW     = $clog2(ROUNDS);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SEL   = 4'd1;
  localparam logic [3:0] ST_RED   = 4'd2;
  localparam logic [3:0] ST_ROUND = 4'd3;
  localparam logic [3:0] ST_WAIT1 = 4'd4;
  localparam logic [3:0] ST_FIN1  = 4'd5;
  localparam logic [3:0] ST_WAIT2 = 4'd6;
  localparam logic [3:0] ST_FIN2  = 4'd7;
  localparam logic [3:0] ST_WAIT3 = 4'd8;
  localparam logic [3:0] ST_EMIT  = 4'd9;

  localparam logic [2:0] LAST_SLOT = 3'd4;

  logic [3:0]    state_r, state_nxt;
  logic [2:0]    slot_r, slot_nxt;
  logic [RW-1:0] round_r, round_nxt;
  logic [1:0]    red_r, red_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_free;

  assign out_free = !out_valid_r || !out_stall;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    round_nxt = round_r;
    red_nxt   = red_r;
    cmd       = '0;
    cmd.red_sel = red_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        slot_nxt  = 3'd0;
        round_nxt = '0;
        red_nxt   = mgrp_pkg::RED_FIRST;
        state_nxt = sts.one ? ST_RED : ST_ROUND;
      end
      ST_RED: begin
        cmd.red_step = 1'b1;
        red_nxt      = red_r - 2'd1;
        if (red_r == 2'd0) begin
          state_nxt = ST_FIN1;
        end
      end
      ST_ROUND: begin
        // five interleaved multiplies per exponent bit
        cmd.issue = 1'b1;
        case (slot_r)
          3'd0:    cmd.op = mgrp_pkg::OP_SQB;
          3'd1:    cmd.op = mgrp_pkg::OP_HI;
          3'd2:    cmd.op = mgrp_pkg::OP_LO;
          3'd3:    cmd.op = mgrp_pkg::OP_SQC;
          default: cmd.op = mgrp_pkg::OP_INV;
        endcase
        slot_nxt = slot_r + 3'd1;
        if (slot_r == LAST_SLOT) begin
          cmd.shift = 1'b1;
          slot_nxt  = 3'd0;
          round_nxt = round_r + RW'(1);
          if (round_r == RW'(ROUNDS - 1)) begin
            state_nxt = ST_WAIT1;
          end
        end
      end
      ST_WAIT1: begin
        if (!sts.busy) begin
          state_nxt = ST_FIN1;
        end
      end
      ST_FIN1: begin
        cmd.issue = 1'b1;
        cmd.op    = mgrp_pkg::OP_TERM;
        state_nxt = ST_WAIT2;
      end
      ST_WAIT2: begin
        if (!sts.busy) begin
          state_nxt = ST_FIN2;
        end
      end
      ST_FIN2: begin
        cmd.issue = 1'b1;
        cmd.op    = mgrp_pkg::OP_PROD;
        state_nxt = ST_WAIT3;
      end
      ST_WAIT3: begin
        if (!sts.busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts.last) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    priority if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= 3'd0;
      round_r     <= '0;
      red_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      round_r     <= round_nxt;
      red_r       <= red_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
